FILE: hw/rtl/clw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_pkg
// Shared types, register map and start-up command list of the 4-bit LCD
// write sequencer.
// ----------------------------------------------------------------------------
package clw_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int LEN_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int INIT_STEPS  = 8;
    localparam int STEP_WIDTH  = $clog2(INIT_STEPS);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [7:0] CMD_CLEAR = 8'h01;

    localparam int ADDR_WIDTH = 5;

    typedef enum logic [2:0] {
        REG_ENABLE_PULSE = 3'd0,
        REG_NIBBLE_GAP   = 3'd1,
        REG_BYTE_GAP     = 3'd2,
        REG_INIT_GAP     = 3'd3,
        REG_CLEAR_WAIT   = 3'd4,
        REG_POWER_UP     = 3'd5
    } t_reg_index;

    typedef enum logic [2:0] {
        PH_POWER = 3'd0,
        PH_EHIGH = 3'd1,
        PH_NGAP  = 3'd2,
        PH_BGAP  = 3'd3,
        PH_CLEAR = 3'd4,
        PH_IGAP  = 3'd5,
        PH_IDLE  = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0]  enable_pulse_ticks;
        logic [7:0]  nibble_gap_ticks;
        logic [9:0]  byte_gap_ticks;
        logic [9:0]  init_gap_ticks;
        logic [15:0] clear_wait_ticks;
        logic [15:0] power_up_ticks;
    } t_cfg;

    typedef struct packed {
        logic       rs_pin;
        logic       enable_pin;
        logic [3:0] data_pins;
        logic       busy_res;
        logic       ready_done;
        logic       write_dropped;
    } t_result;

    function automatic logic [7:0] init_byte(input logic [STEP_WIDTH-1:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = 8'h30;
            3'd1:    b = 8'h20;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h28;
            3'd4:    b = CMD_CLEAR;
            3'd5:    b = 8'h06;
            3'd6:    b = 8'h0E;
            default: b = 8'h0C;
        endcase
        return b;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_len(input logic [15:0] d);
        logic [LEN_WIDTH-1:0] d_ext;
        d_ext = LEN_WIDTH'(d);
        if (d_ext > LEN_WIDTH'(COUNT_MAX)) begin
            return COUNT_MAX;
        end
        return COUNT_WIDTH'(d_ext);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/clw_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_regs
// APB-style timing register file of the LCD write sequencer.
// ----------------------------------------------------------------------------
module clw_regs
    import clw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output      logic [31:0]           prdata,
    output      logic                  pready,
    output      t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_WIDTH-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_pulse_ticks <= 8'd2;
            r_cfg.nibble_gap_ticks   <= 8'd5;
            r_cfg.byte_gap_ticks     <= 10'd50;
            r_cfg.init_gap_ticks     <= 10'd40;
            r_cfg.clear_wait_ticks   <= 16'd2000;
            r_cfg.power_up_ticks     <= 16'd60000;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ENABLE_PULSE: r_cfg.enable_pulse_ticks <= pwdata[7:0];
                REG_NIBBLE_GAP:   r_cfg.nibble_gap_ticks   <= pwdata[7:0];
                REG_BYTE_GAP:     r_cfg.byte_gap_ticks     <= pwdata[9:0];
                REG_INIT_GAP:     r_cfg.init_gap_ticks     <= pwdata[9:0];
                REG_CLEAR_WAIT:   r_cfg.clear_wait_ticks   <= pwdata[15:0];
                REG_POWER_UP:     r_cfg.power_up_ticks     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENABLE_PULSE: prdata = {24'd0, r_cfg.enable_pulse_ticks};
            REG_NIBBLE_GAP:   prdata = {24'd0, r_cfg.nibble_gap_ticks};
            REG_BYTE_GAP:     prdata = {22'd0, r_cfg.byte_gap_ticks};
            REG_INIT_GAP:     prdata = {22'd0, r_cfg.init_gap_ticks};
            REG_CLEAR_WAIT:   prdata = {16'd0, r_cfg.clear_wait_ticks};
            REG_POWER_UP:     prdata = {16'd0, r_cfg.power_up_ticks};
            default:          prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/clw_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_seq
// Phase state machine with its up-counter: applies one tick or write
// request per step and gives the pin levels that follow it.
// ----------------------------------------------------------------------------
module clw_seq
    import clw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_reg_select,
    input  wire t_cfg       i_cfg,
    output      t_result    o_result
);

    t_phase                  r_phase, n_phase;
    logic [STEP_WIDTH-1:0]   r_init_step, n_init_step;
    logic [COUNT_WIDTH-1:0]  r_wait_count, n_wait_count;
    logic [7:0]              r_held_byte, n_held_byte;
    logic                    r_held_select, n_held_select;
    logic                    r_low_half_next, n_low_half_next;
    logic                    r_started, n_started;

    logic                    dropped;
    logic                    fin;
    logic                    nxt;
    logic [COUNT_WIDTH-1:0]  cnt;
    logic [COUNT_WIDTH-1:0]  len;
    logic [STEP_WIDTH:0]     step_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_POWER;
            r_init_step     <= '0;
            r_wait_count    <= '0;
            r_held_byte     <= '0;
            r_held_select   <= 1'b0;
            r_low_half_next <= 1'b0;
            r_started       <= 1'b0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_init_step     <= n_init_step;
            r_wait_count    <= n_wait_count;
            r_held_byte     <= n_held_byte;
            r_held_select   <= n_held_select;
            r_low_half_next <= n_low_half_next;
            r_started       <= n_started;
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_POWER: len = sat_len(i_cfg.power_up_ticks);
            PH_EHIGH: len = sat_len({8'd0, i_cfg.enable_pulse_ticks});
            PH_NGAP:  len = sat_len({8'd0, i_cfg.nibble_gap_ticks});
            PH_BGAP:  len = sat_len({6'd0, i_cfg.byte_gap_ticks});
            PH_CLEAR: len = sat_len(i_cfg.clear_wait_ticks);
            default:  len = sat_len({6'd0, i_cfg.init_gap_ticks});
        endcase
    end

    always_comb begin
        n_phase         = r_phase;
        n_init_step     = r_init_step;
        n_wait_count    = r_wait_count;
        n_held_byte     = r_held_byte;
        n_held_select   = r_held_select;
        n_low_half_next = r_low_half_next;
        n_started       = r_started;
        dropped         = 1'b0;
        fin             = 1'b0;
        nxt             = 1'b0;
        cnt             = (r_wait_count < COUNT_MAX) ? r_wait_count + 1'b1 : r_wait_count;
        step_inc        = {1'b0, r_init_step} + 1'b1;

        if (i_req_type) begin
            if (r_phase == PH_IDLE) begin
                n_held_byte     = i_byte_value;
                n_held_select   = i_reg_select;
                n_low_half_next = 1'b0;
                n_phase         = PH_EHIGH;
                n_wait_count    = '0;
            end else begin
                dropped = 1'b1;
            end
        end else if (r_phase != PH_IDLE) begin
            n_wait_count = cnt;
            if (cnt >= len) begin
                n_wait_count = '0;
                unique case (r_phase)
                    PH_POWER: begin
                        n_init_step     = '0;
                        n_held_byte     = init_byte('0);
                        n_held_select   = 1'b0;
                        n_low_half_next = 1'b0;
                        n_phase         = PH_EHIGH;
                    end
                    PH_EHIGH: begin
                        n_phase = PH_NGAP;
                    end
                    PH_NGAP: begin
                        if (!r_started && r_init_step < STEP_WIDTH'(2)) begin
                            fin = 1'b1;
                        end else if (!r_low_half_next) begin
                            n_low_half_next = 1'b1;
                            n_phase         = PH_EHIGH;
                        end else begin
                            n_phase = PH_BGAP;
                        end
                    end
                    PH_BGAP: begin
                        if (!r_held_select && r_held_byte == CMD_CLEAR) begin
                            n_phase = PH_CLEAR;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    PH_CLEAR: begin
                        fin = 1'b1;
                    end
                    default: begin
                        nxt = 1'b1;
                    end
                endcase
                if (fin) begin
                    if (!r_started && r_init_step < STEP_WIDTH'(4)) begin
                        n_phase = PH_IGAP;
                    end else begin
                        nxt = 1'b1;
                    end
                end
                if (nxt) begin
                    if (r_started) begin
                        n_phase = PH_IDLE;
                    end else if (step_inc[STEP_WIDTH]) begin
                        n_init_step = '0;
                        n_started   = 1'b1;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_init_step     = step_inc[STEP_WIDTH-1:0];
                        n_held_byte     = init_byte(step_inc[STEP_WIDTH-1:0]);
                        n_held_select   = 1'b0;
                        n_low_half_next = 1'b0;
                        n_phase         = PH_EHIGH;
                    end
                end
            end
        end

        o_result.rs_pin        = n_held_select;
        o_result.enable_pin    = (n_phase == PH_EHIGH);
        o_result.data_pins     = n_low_half_next ? n_held_byte[3:0] : n_held_byte[7:4];
        o_result.busy_res      = (n_phase != PH_IDLE);
        o_result.ready_done    = n_started;
        o_result.write_dropped = dropped;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/char_lcd_4bit_write_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer
// Tick-driven driver for a character LCD on a 4-bit bus: power-up wait,
// fixed start-up list, then byte writes as two enable-strobed nibbles.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   req_type, byte_value, reg_select
// result    out        o_out_valid / i_out_ready pin levels and status
// config    in         APB psel/penable/pready   six timing registers
//
// Each transaction passes through the input register and then the result
// register; one transaction is accepted per cycle while the result is not
// stalled. The phase state machine and its counter update as a transaction
// moves into the result register. Reset is synchronous and clears
// control state and timing registers. A stalled result holds the input
// register, and o_in_ready falls only while the input register is full and
// its transaction cannot move into the result register.
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_sequencer
    import clw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire logic                  i_req_type,
    input  wire logic [7:0]            i_byte_value,
    input  wire logic                  i_reg_select,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      logic                  o_rs_pin,
    output      logic                  o_enable_pin,
    output      logic [3:0]            o_data_pins,
    output      logic                  o_busy_res,
    output      logic                  o_ready_done,
    output      logic                  o_write_dropped,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output      logic [31:0]           prdata,
    output      logic                  pready
);

    t_cfg       cfg;
    t_result    result;
    t_result    r_out;
    logic       r_out_valid;
    logic       r_in_valid;
    logic       r_req_type;
    logic [7:0] r_byte_value;
    logic       r_reg_select;
    logic       advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    clw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    clw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_req_type   (r_req_type),
        .i_byte_value (r_byte_value),
        .i_reg_select (r_reg_select),
        .i_cfg        (cfg),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type   <= i_req_type;
            r_byte_value <= i_byte_value;
            r_reg_select <= i_reg_select;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rs_pin        = r_out.rs_pin;
    assign o_enable_pin    = r_out.enable_pin;
    assign o_data_pins     = r_out.data_pins;
    assign o_busy_res      = r_out.busy_res;
    assign o_ready_done    = r_out.ready_done;
    assign o_write_dropped = r_out.write_dropped;

    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_dropped |-> o_busy_res)
        else $error("Dropped write reported while idle.");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_enable_pin |-> o_busy_res)
        else $error("Enable strobe high while idle.");

    a_init_rs_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ready_done |-> !o_rs_pin)
        else $error("Register select high during start-up.");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("Input accepted while the pipeline is stalled.");

endmodule
`default_nettype wire
